### rtl/gwm_pkg.sv
package gwm_pkg;

    localparam logic [1:0] FUNC_PAT_BYTE = 2'd0;
    localparam logic [1:0] FUNC_PAT_END  = 2'd1;
    localparam logic [1:0] FUNC_TXT_BYTE = 2'd2;
    localparam logic [1:0] FUNC_TXT_END  = 2'd3;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } out_item_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic       use_start;
        logic       step;
        logic       reset_vec;
        logic       clear_en;
        logic       load;
        logic [7:0] ch;
    } cell_ctrl_t;

endpackage

### rtl/glob_wildcard_matcher.sv
// result: registered, valid in the cycle after its end-of-text item is accepted
// throughput: one item per cycle while the output does not stall; every text byte updates all cells at once
// the star closure ripples through the row of cells like a carry chain
// output register stalls the input only while a result waits and m_ready is low
// reset: empty pattern, closed, no overflow, only position zero active
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [LW-1:0] len_reg, len_next, eff_len;
    logic          closed_reg, closed_next;
    logic          too_long_reg, too_long_next;
    logic          last_act_reg, last_act_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_item_reg, m_item_next;

    cell_ctrl_t ctrl;
    logic       acc;

    logic [MAX_PATTERN-1:0] cout_w, sout_w, en_w;
    logic [MAX_PATTERN:0]   closed_w, end_w;
    logic                   end_hit;

    assign s_ready = ~m_valid_reg | m_ready;
    assign acc     = s_valid & s_ready;
    assign eff_len = closed_reg ? '0 : len_reg;

    always_comb begin
        ctrl.use_start = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.reset_vec = 1'b0;
        ctrl.clear_en  = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.ch        = s_item.ch;
        if (acc) begin
            case (s_item.func)
                FUNC_PAT_BYTE: begin
                    ctrl.reset_vec = closed_reg;
                    ctrl.clear_en  = closed_reg;
                    ctrl.load      = (eff_len < LW'(MAX_PATTERN));
                end
                FUNC_PAT_END: begin
                    ctrl.reset_vec = 1'b1;
                end
                FUNC_TXT_BYTE: begin
                    ctrl.use_start = ~closed_reg;
                    ctrl.step      = 1'b1;
                end
                FUNC_TXT_END: begin
                    ctrl.use_start = ~closed_reg;
                    ctrl.reset_vec = 1'b1;
                end
                default: begin
                    ctrl.reset_vec = 1'b0;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            gwm_cell #(
                .IDX (gi),
                .LW  (LW)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .wr_idx  (eff_len),
                .cin     ((gi == 0) ? 1'b0 : cout_w[(gi == 0) ? 0 : gi-1]),
                .sin     ((gi == 0) ? 1'b0 : sout_w[(gi == 0) ? 0 : gi-1]),
                .cout    (cout_w[gi]),
                .sout    (sout_w[gi]),
                .closed  (closed_w[gi]),
                .en      (en_w[gi])
            );
            // the first disabled cell marks the end of the pattern
            if (gi == 0) begin : g_end0
                assign end_w[gi] = ~en_w[gi];
            end else begin : g_endn
                assign end_w[gi] = ~en_w[gi] & en_w[gi-1];
            end
        end
    endgenerate

    assign closed_w[MAX_PATTERN] = (ctrl.use_start ? 1'b0 : last_act_reg)
                                   | cout_w[MAX_PATTERN-1];
    assign end_w[MAX_PATTERN]    = en_w[MAX_PATTERN-1];
    assign end_hit               = |(closed_w & end_w);

    always_comb begin
        len_next      = len_reg;
        closed_next   = closed_reg;
        too_long_next = too_long_reg;
        last_act_next = last_act_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_item_next   = m_item_reg;
        if (ctrl.step) begin
            last_act_next = sout_w[MAX_PATTERN-1];
        end else if (ctrl.reset_vec) begin
            last_act_next = 1'b0;
        end
        if (acc) begin
            case (s_item.func)
                FUNC_PAT_BYTE: begin
                    closed_next = 1'b0;
                    if (eff_len < LW'(MAX_PATTERN)) begin
                        len_next      = eff_len + LW'(1);
                        too_long_next = closed_reg ? 1'b0 : too_long_reg;
                    end else begin
                        len_next      = eff_len;
                        too_long_next = 1'b1;
                    end
                end
                FUNC_PAT_END, FUNC_TXT_BYTE: begin
                    closed_next = 1'b1;
                end
                FUNC_TXT_END: begin
                    closed_next          = 1'b1;
                    m_valid_next         = 1'b1;
                    m_item_next.matched  = end_hit & ~too_long_reg;
                    m_item_next.overflow = too_long_reg;
                end
                default: begin
                    closed_next = closed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            closed_reg   <= 1'b1;
            too_long_reg <= 1'b0;
            last_act_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            closed_reg   <= closed_next;
            too_long_reg <= too_long_next;
            last_act_reg <= last_act_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### rtl/gwm_cell.sv
module gwm_cell
    import gwm_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cell_ctrl_t    ctrl,
    input  logic [LW-1:0] wr_idx,
    input  logic          cin,
    input  logic          sin,
    output logic          cout,
    output logic          sout,
    output logic          closed,
    output logic          en
);

    localparam logic IS_FIRST = (IDX == 0);

    logic       act_reg, act_next;
    logic       en_reg, en_next;
    logic [7:0] byte_reg;
    logic       act_eff, is_star, is_hit, wr_me;

    assign wr_me   = ctrl.load && (wr_idx == LW'(IDX));
    assign act_eff = ctrl.use_start ? IS_FIRST : act_reg;
    assign closed  = act_eff | cin;
    assign is_star = (byte_reg == STAR_BYTE);
    assign is_hit  = (byte_reg == ANY_BYTE) || (byte_reg == ctrl.ch);
    assign cout    = closed & en_reg & is_star;
    assign sout    = closed & en_reg & ~is_star & is_hit;
    assign en      = en_reg;

    always_comb begin
        if (ctrl.step) begin
            act_next = cout | sin;
        end else if (ctrl.reset_vec) begin
            act_next = IS_FIRST;
        end else begin
            act_next = act_reg;
        end
        if (wr_me) begin
            en_next = 1'b1;
        end else if (ctrl.clear_en) begin
            en_next = 1'b0;
        end else begin
            en_next = en_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= IS_FIRST;
            en_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            en_reg  <= en_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_me) begin
            byte_reg <= ctrl.ch;
        end
    end

endmodule
